// File: src/bte_pkg.sv
// Package with the shared types, codes and constants of the bencode token emitter.
package bte_pkg;

  localparam int DEF_INT_WIDTH    = 32;
  localparam int DEF_LENGTH_WIDTH = 32;

  localparam logic [2:0] KIND_LIST    = 3'd0;
  localparam logic [2:0] KIND_DICT    = 3'd1;
  localparam logic [2:0] KIND_END     = 3'd2;
  localparam logic [2:0] KIND_INT     = 3'd3;
  localparam logic [2:0] KIND_STR     = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;

  localparam logic [7:0] CH_LIST  = 8'h6C;
  localparam logic [7:0] CH_DICT  = 8'h64;
  localparam logic [7:0] CH_END   = 8'h65;
  localparam logic [7:0] CH_INT   = 8'h69;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_CONV,
    S_DIGIT,
    S_TAIL
  } state_t;

  typedef struct packed {
    logic load;
    logic next_digit;
  } dab_cmd_t;

  // Decimal digits needed for an unsigned value of w bits (77/256 approximates log10 2).
  function automatic int num_digits(input int w);
    return (w * 77) / 256 + 1;
  endfunction

endpackage

// File: src/bte_dabble.sv
// Bit-serial binary to BCD converter with a digit shift-out port.
module bte_dabble
  import bte_pkg::*;
#(
  parameter int WIDTH = DEF_INT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  dab_cmd_t         cmd,
  input  logic [WIDTH-1:0] value,
  output logic             done,
  output logic [3:0]       top_digit
);

  localparam int DIGITS = num_digits(WIDTH);
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] count;

  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < DIGITS; i++) begin
      d = bcd[i*4 +: 4];
      adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= CNT_W'(WIDTH);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value;
      bcd <= '0;
    end else if (count != '0) begin
      bcd <= {adj[BCD_W-2:0], bin[WIDTH-1]};
      bin <= {bin[WIDTH-2:0], 1'b0};
    end else if (cmd.next_digit) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign done      = (count == '0);
  assign top_digit = bcd[BCD_W-1 -: 4];

endmodule

// File: src/bencode_token_emitter_unit.sv
// Top level of the bencode token emitter: event decode, sequencing and output register.
//
// Each transfer on the input channel (in_valid, in_ready) carries one serializer
// event; kinds 0 to 5 answer with one or more transfers on the output channel
// (out_valid, out_ready), one bencoded byte each, with last set on the final byte.
// Container marks and payload bytes go straight into the output register, so a new
// event can be taken in the cycle after and payload streams at one byte per cycle
// while the receiver keeps up. Integers and string headers go through a bit-serial
// double-dabble converter: the magnitude shifts in one bit per cycle, overlapped
// with the 'i' and '-' bytes. The decimal digits then shift out one per cycle while
// the receiver keeps up, leading zeros skipped without output, followed by 'e' or
// ':'. A number therefore holds off the next event until that final byte has
// entered the output register.
// The result byte sits in an output register, so the next byte is prepared while
// it waits; when the receiver stalls, the sequence simply holds. Kinds 6 and 7 are
// accepted and produce nothing. Synchronous reset empties the output register and
// returns the sequencer to idle; no event in flight survives it.
module bencode_token_emitter_unit
  import bte_pkg::*;
#(
  parameter int INT_WIDTH    = DEF_INT_WIDTH,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     kind,
  input  logic signed [INT_WIDTH-1:0]    int_word,
  input  logic [LENGTH_WIDTH-1:0]        str_len,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           last
);

  localparam int CONV_W = (INT_WIDTH > LENGTH_WIDTH) ? INT_WIDTH : LENGTH_WIDTH;
  localparam int DIGITS = num_digits(CONV_W);
  localparam int DIG_W  = $clog2(DIGITS);

  state_t state, state_next;

  logic             is_int;
  logic             started;
  logic [DIG_W-1:0] cnt;

  logic             out_free;
  logic             accept;
  logic             out_load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic             digit_step;
  logic             digit_emit;
  dab_cmd_t         cmd;
  logic             conv_done;
  logic [3:0]       top_digit;
  logic             neg_in;
  logic [INT_WIDTH-1:0] mag;
  logic [CONV_W-1:0]    conv_value;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign neg_in   = int_word[INT_WIDTH-1];
  assign mag      = neg_in ? ((~$unsigned(int_word)) + INT_WIDTH'(1)) : $unsigned(int_word);
  assign conv_value = (kind == KIND_INT) ? CONV_W'(mag) : CONV_W'(str_len);
  assign digit_emit = started || (top_digit != 4'd0) || (cnt == '0);

  bte_dabble #(
    .WIDTH(CONV_W)
  ) u_dabble (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (conv_value),
    .done     (conv_done),
    .top_digit(top_digit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_INT) begin
            state_next = neg_in ? S_SIGN : S_CONV;
          end else if (kind == KIND_STR) begin
            state_next = S_CONV;
          end
        end
      end
      S_SIGN: begin
        if (out_free) state_next = S_CONV;
      end
      S_CONV: begin
        if (conv_done) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (digit_step && cnt == '0) state_next = S_TAIL;
      end
      S_TAIL: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    load_byte  = CH_END;
    load_last  = 1'b0;
    digit_step = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          unique case (kind)
            KIND_LIST: begin
              out_load  = 1'b1;
              load_byte = CH_LIST;
              load_last = 1'b1;
            end
            KIND_DICT: begin
              out_load  = 1'b1;
              load_byte = CH_DICT;
              load_last = 1'b1;
            end
            KIND_END: begin
              out_load  = 1'b1;
              load_byte = CH_END;
              load_last = 1'b1;
            end
            KIND_INT: begin
              out_load  = 1'b1;
              load_byte = CH_INT;
              cmd.load  = 1'b1;
            end
            KIND_STR: begin
              cmd.load = 1'b1;
            end
            KIND_PAYLOAD: begin
              out_load  = 1'b1;
              load_byte = data_byte;
              load_last = 1'b1;
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      S_SIGN: begin
        out_load  = out_free;
        load_byte = CH_MINUS;
      end
      S_CONV: begin
        out_load = 1'b0;
      end
      S_DIGIT: begin
        if (digit_emit) begin
          out_load   = out_free;
          load_byte  = CH_ZERO | {4'd0, top_digit};
          digit_step = out_free;
        end else begin
          digit_step = 1'b1;
        end
      end
      S_TAIL: begin
        out_load  = out_free;
        load_byte = is_int ? CH_END : CH_COLON;
        load_last = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    cmd.next_digit = digit_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_int <= (kind == KIND_INT);
    end
    if (state == S_CONV && conv_done) begin
      cnt     <= DIG_W'(DIGITS - 1);
      started <= 1'b0;
    end else if (digit_step) begin
      cnt <= cnt - 1'b1;
      if (digit_emit) started <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= load_byte;
      last     <= load_last;
    end
  end

endmodule

// File: bench/bencode_token_emitter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bencode token emitter, driven by directed and random events.
module bencode_token_emitter_unit_tb;
  import bte_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int RADIX = 10;
  localparam int RANDOM_EVENTS = 400;
  localparam int IDLE_PCT = 8;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = KIND_LIST;
  logic signed [31:0] int_word = '0;
  logic [31:0] str_len = '0;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic last;

  logic calm = 1'b0;
  bit pin_typed = 1'b0;
  string pin_want = "";

  enc_byte_t encoded_q[$];
  int kind_count[8];
  int bytes_checked = 0;
  int errors = 0;
  int cycles = 0;
  int events_sent = 0;

  logic [2:0] row_kind[$];
  logic [31:0] row_int[$];
  logic [31:0] row_len[$];
  logic [7:0] row_byte[$];
  bit row_typed[$];
  string row_want[$];

  bencode_token_emitter_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .int_word(int_word),
    .str_len(str_len),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic push_byte(input logic [7:0] code, input logic is_last);
    encoded_q.push_back('{code: code, last: is_last});
  endtask

  task automatic push_decimal(input logic [31:0] value);
    logic [7:0] digits[$];
    logic [31:0] rest;
    rest = value;
    do begin
      digits.push_front(CH_ZERO + 8'(rest % RADIX));
      rest = rest / RADIX;
    end while (rest != 0);
    foreach (digits[i]) push_byte(digits[i], 1'b0);
  endtask

  task automatic predict_encoding(input logic [2:0] k, input logic signed [31:0] iv,
                                  input logic [31:0] len, input logic [7:0] db);
    logic [31:0] magnitude;
    case (k)
      KIND_LIST: push_byte(CH_LIST, 1'b1);
      KIND_DICT: push_byte(CH_DICT, 1'b1);
      KIND_END: push_byte(CH_END, 1'b1);
      KIND_INT: begin
        push_byte(CH_INT, 1'b0);
        magnitude = iv;
        if (iv < 0) begin
          push_byte(CH_MINUS, 1'b0);
          magnitude = ~iv + 32'd1;
        end
        push_decimal(magnitude);
        push_byte(CH_END, 1'b1);
      end
      KIND_STR: begin
        push_decimal(len);
        push_byte(CH_COLON, 1'b1);
      end
      KIND_PAYLOAD: push_byte(db, 1'b1);
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [2:0] k, input logic [31:0] iv, input logic [31:0] len,
                         input logic [7:0] db, input bit typed, input string want);
    row_kind.push_back(k);
    row_int.push_back(iv);
    row_len.push_back(len);
    row_byte.push_back(db);
    row_typed.push_back(typed);
    row_want.push_back(want);
  endtask

  task automatic send_item(input logic [2:0] k, input logic [31:0] iv, input logic [31:0] len,
                           input logic [7:0] db, input bit typed, input string want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    int_word <= iv;
    str_len <= len;
    data_byte <= db;
    pin_typed <= typed;
    pin_want <= want;
    do @(posedge clk); while (!in_ready);
    if (k < KIND_SPARE_LO) events_sent++;
  endtask

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  // Output transfers are checked before the input transfer of the same edge is predicted.
  always @(posedge clk) begin : scoreboard
    enc_byte_t head;
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (encoded_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected byte %h last %b at cycle %0d", out_byte, last, cycles);
      end else begin
        head = encoded_q.pop_front();
        if (out_byte !== head.code || last !== head.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at cycle %0d: expected byte %h last %b, got byte %h last %b",
                     cycles, head.code, head.last, out_byte, last);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      kind_count[kind]++;
      if (pin_typed) begin
        for (int i = 0; i < pin_want.len(); i++)
          push_byte(pin_want[i], i == pin_want.len() - 1);
      end else begin
        predict_encoding(kind, int_word, str_len, data_byte);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, encoded_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int depth;
    int pick;
    int n;
    logic [31:0] iv;

    add_row(KIND_LIST, '0, '0, '0, 1'b1, "l");
    add_row(KIND_DICT, '1, '1, '1, 1'b1, "d");
    add_row(KIND_END, 32'h5555_5555, 32'hAAAA_AAAA, 8'h5A, 1'b1, "e");
    add_row(KIND_INT, 32'd0, '1, '1, 1'b1, "i0e");
    add_row(KIND_INT, 32'h7FFF_FFFF, '0, '0, 1'b1, "i2147483647e");
    add_row(KIND_INT, 32'h8000_0000, '0, '0, 1'b1, "i-2147483648e");
    add_row(KIND_INT, 32'hFFFF_FFFF, '1, '1, 1'b1, "i-1e");
    add_row(KIND_INT, 32'd9, '0, '0, 1'b1, "i9e");
    add_row(KIND_INT, 32'd10, '0, '0, 1'b1, "i10e");
    add_row(KIND_INT, -32'sd1000000000, '1, '1, 1'b0, "");
    add_row(KIND_INT, 32'd123456789, 32'd77, 8'h41, 1'b0, "");
    add_row(KIND_STR, 32'h8000_0000, 32'd0, 8'hFF, 1'b1, "0:");
    add_row(KIND_STR, '0, 32'hFFFF_FFFF, '0, 1'b1, "4294967295:");
    add_row(KIND_STR, '1, 32'd1000000000, '1, 1'b0, "");
    add_row(KIND_STR, '1, 32'd5, '1, 1'b0, "");
    add_row(KIND_PAYLOAD, '0, '0, 8'h00, 1'b0, "");
    add_row(KIND_PAYLOAD, '1, '1, 8'hFF, 1'b0, "");
    add_row(KIND_PAYLOAD, '0, '1, 8'h80, 1'b0, "");
    add_row(KIND_PAYLOAD, '1, '0, 8'h7F, 1'b0, "");
    add_row(KIND_PAYLOAD, 32'd3, 32'd3, 8'h3A, 1'b0, "");
    add_row(KIND_SPARE_LO, 32'd7, 32'd7, 8'h65, 1'b1, "");
    add_row(KIND_SPARE_HI, '1, '1, '1, 1'b1, "");
    add_row(KIND_END, '1, '0, '1, 1'b1, "e");

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (row_kind[r])
      send_item(row_kind[r], row_int[r], row_len[r], row_byte[r], row_typed[r], row_want[r]);

    // Random part: mostly well-nested containers with headers followed by their payload,
    // with some stray events of any kind mixed in.
    events_sent = 0;
    depth = 0;
    while (events_sent < RANDOM_EVENTS) begin
      calm <= (events_sent >= 150 && events_sent < 240);
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(3'($urandom_range(7)), $urandom, $urandom, 8'($urandom), 1'b0, "");
      end else if (pick < 32 && depth > 0) begin
        send_item(KIND_END, $urandom, $urandom, 8'($urandom), 1'b0, "");
        depth--;
      end else if (pick < 47 && depth < 6) begin
        send_item(pick[0] ? KIND_LIST : KIND_DICT, $urandom, $urandom, 8'($urandom), 1'b0, "");
        depth++;
      end else if (pick < 67) begin
        iv = $urandom >> $urandom_range(31);
        if ($urandom_range(1) == 1) iv = -iv;
        send_item(KIND_INT, iv, $urandom, 8'($urandom), 1'b0, "");
      end else begin
        n = $urandom_range(7);
        send_item(KIND_STR, $urandom, n, 8'($urandom), 1'b0, "");
        repeat (n) send_item(KIND_PAYLOAD, $urandom, $urandom, 8'($urandom), 1'b0, "");
      end
    end
    while (depth > 0) begin
      send_item(KIND_END, $urandom, $urandom, 8'($urandom), 1'b0, "");
      depth--;
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    @(posedge clk);
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("events: %0d list, %0d dict, %0d end, %0d integer, %0d header, %0d payload, %0d unused",
             kind_count[KIND_LIST], kind_count[KIND_DICT], kind_count[KIND_END],
             kind_count[KIND_INT], kind_count[KIND_STR], kind_count[KIND_PAYLOAD],
             kind_count[KIND_SPARE_LO] + kind_count[KIND_SPARE_HI]);
    $display("output bytes checked: %0d, mismatches: %0d", bytes_checked, errors);
    if (errors == 0 && encoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
